// ===== rtl/tcd_pkg.sv =====
package tcd_pkg;

    localparam int TOKEN_CAP   = 32;
    localparam int KEY_LEN     = 16;
    localparam int TEXT_LEN    = 16;
    localparam int SLOT_COUNT  = 3;
    localparam int STORE_DEPTH = SLOT_COUNT * TOKEN_CAP;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int LEN_W       = $clog2(TOKEN_CAP);
    localparam int SLOT_W      = 2;
    localparam int KW_COUNT    = 57;
    localparam int FLAG_COUNT  = 6;
    localparam int KW_TEXT_W   = 80;
    localparam int NUM_W       = 32;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7a;
    localparam logic [7:0] CH_CASE  = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_X     = 8'h58;

    typedef enum logic [5:0] {
        CMD_NONE, CMD_UNKNOWN, CMD_STATUS, CMD_SAFETY, CMD_CONFIG, CMD_SET, CMD_SAVE,
        CMD_RESETCFG, CMD_REBOOT, CMD_BOOTLOADER, CMD_BOOT, CMD_ENABLE, CMD_DISABLE,
        CMD_HOLD, CMD_DRIVER, CMD_IRUN, CMD_IHOLD, CMD_IHOLDDELAY, CMD_SGTHRS,
        CMD_MOVEABS, CMD_MOVEREL, CMD_SETPOS, CMD_CYCLE, CMD_PRESSPOS, CMD_SIMLOAD,
        CMD_SIMTHRESH, CMD_SIMMECH, CMD_SIMSTALL, CMD_SIMCLEAR, CMD_TARE,
        CMD_PANELPINS, CMD_HOME, CMD_STOP, CMD_BACKOFF, CMD_HELP
    } cmd_t;

    typedef enum logic [2:0] {
        ARG_NONE, ARG_I32, ARG_U32, ARG_BOOL, ARG_AXIS, ARG_KEY, ARG_PAIR
    } arg_t;

    typedef enum logic [1:0] {
        RK_SUMMARY, RK_KEY, RK_TEXT
    } rkind_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DECODE, ST_KEY_RD, ST_KEY_WR, ST_TEXT_RD, ST_TEXT_WR
    } seq_state_t;

    typedef struct packed {
        logic [KW_TEXT_W-1:0] text;
        logic [3:0]           len;
        cmd_t                 cmd;
        arg_t                 arg;
        logic                 mm;
    } kw_t;

    // token scanner status handed to the sequencer
    typedef struct packed {
        logic [SLOT_COUNT-1:0][LEN_W-1:0] len;
        logic             kw_found;
        logic [5:0]       kw_cmd;
        logic [2:0]       kw_arg;
        logic             kw_mm;
        logic             flag_on;
        logic             flag_off;
        logic [7:0]       c0;
        logic [7:0]       c1;
        logic [NUM_W-1:0] acc0;
        logic [NUM_W-1:0] acc1;
        logic [NUM_W-1:0] acc2;
        logic             ok0;
        logic             ok1;
        logic             ok2;
    } scan_status_t;

    function automatic kw_t kw_entry(int i);
        case (i)
            0:  return '{"STATUS",     4'd6,  CMD_STATUS,     ARG_NONE, 1'b0};
            1:  return '{"M114",       4'd4,  CMD_STATUS,     ARG_NONE, 1'b0};
            2:  return '{"M119",       4'd4,  CMD_STATUS,     ARG_NONE, 1'b0};
            3:  return '{"SAFETY",     4'd6,  CMD_SAFETY,     ARG_NONE, 1'b0};
            4:  return '{"M122",       4'd4,  CMD_SAFETY,     ARG_NONE, 1'b0};
            5:  return '{"CONFIG",     4'd6,  CMD_CONFIG,     ARG_KEY,  1'b0};
            6:  return '{"CFG",        4'd3,  CMD_CONFIG,     ARG_KEY,  1'b0};
            7:  return '{"SET",        4'd3,  CMD_SET,        ARG_PAIR, 1'b0};
            8:  return '{"SAVE",       4'd4,  CMD_SAVE,       ARG_NONE, 1'b0};
            9:  return '{"SAVECFG",    4'd7,  CMD_SAVE,       ARG_NONE, 1'b0};
            10: return '{"RESETCFG",   4'd8,  CMD_RESETCFG,   ARG_NONE, 1'b0};
            11: return '{"DEFAULTCFG", 4'd10, CMD_RESETCFG,   ARG_NONE, 1'b0};
            12: return '{"REBOOT",     4'd6,  CMD_REBOOT,     ARG_NONE, 1'b0};
            13: return '{"RESET",      4'd5,  CMD_REBOOT,     ARG_NONE, 1'b0};
            14: return '{"BOOTLOADER", 4'd10, CMD_BOOTLOADER, ARG_NONE, 1'b0};
            15: return '{"RECOVERY",   4'd8,  CMD_BOOTLOADER, ARG_NONE, 1'b0};
            16: return '{"BOOT",       4'd4,  CMD_BOOT,       ARG_NONE, 1'b0};
            17: return '{"START",      4'd5,  CMD_BOOT,       ARG_NONE, 1'b0};
            18: return '{"ENABLE",     4'd6,  CMD_ENABLE,     ARG_NONE, 1'b0};
            19: return '{"M17",        4'd3,  CMD_ENABLE,     ARG_NONE, 1'b0};
            20: return '{"DISABLE",    4'd7,  CMD_DISABLE,    ARG_NONE, 1'b0};
            21: return '{"M18",        4'd3,  CMD_DISABLE,    ARG_NONE, 1'b0};
            22: return '{"M84",        4'd3,  CMD_DISABLE,    ARG_NONE, 1'b0};
            23: return '{"HOLD",       4'd4,  CMD_HOLD,       ARG_BOOL, 1'b0};
            24: return '{"DRIVER",     4'd6,  CMD_DRIVER,     ARG_NONE, 1'b0};
            // short driver alias
            25: return '{80'h544d43,   4'd3,  CMD_DRIVER,     ARG_NONE, 1'b0};
            26: return '{"IRUN",       4'd4,  CMD_IRUN,       ARG_I32,  1'b0};
            27: return '{"IHOLD",      4'd5,  CMD_IHOLD,      ARG_I32,  1'b0};
            28: return '{"IHOLDDELAY", 4'd10, CMD_IHOLDDELAY, ARG_I32,  1'b0};
            29: return '{"IHOLDD",     4'd6,  CMD_IHOLDDELAY, ARG_I32,  1'b0};
            30: return '{"SGTHRS",     4'd6,  CMD_SGTHRS,     ARG_I32,  1'b0};
            31: return '{"MOVEABS",    4'd7,  CMD_MOVEABS,    ARG_AXIS, 1'b0};
            32: return '{"G0",         4'd2,  CMD_MOVEABS,    ARG_AXIS, 1'b1};
            33: return '{"G1",         4'd2,  CMD_MOVEABS,    ARG_AXIS, 1'b1};
            34: return '{"MOVEREL",    4'd7,  CMD_MOVEREL,    ARG_I32,  1'b0};
            35: return '{"JOG",        4'd3,  CMD_MOVEREL,    ARG_I32,  1'b0};
            36: return '{"SETPOS",     4'd6,  CMD_SETPOS,     ARG_I32,  1'b0};
            37: return '{"CYCLE",      4'd5,  CMD_CYCLE,      ARG_I32,  1'b0};
            38: return '{"PRESSPOS",   4'd8,  CMD_PRESSPOS,   ARG_I32,  1'b0};
            39: return '{"SIMLOAD",    4'd7,  CMD_SIMLOAD,    ARG_U32,  1'b0};
            40: return '{"SIMRAW",     4'd6,  CMD_SIMLOAD,    ARG_U32,  1'b0};
            41: return '{"SIMTHRESH",  4'd9,  CMD_SIMTHRESH,  ARG_U32,  1'b0};
            42: return '{"LOADTHRESH", 4'd10, CMD_SIMTHRESH,  ARG_U32,  1'b0};
            43: return '{"SIMMECH",    4'd7,  CMD_SIMMECH,    ARG_BOOL, 1'b0};
            44: return '{"SIMSTALL",   4'd8,  CMD_SIMSTALL,   ARG_BOOL, 1'b0};
            45: return '{"SIMCLEAR",   4'd8,  CMD_SIMCLEAR,   ARG_NONE, 1'b0};
            46: return '{"ZERO",       4'd4,  CMD_TARE,       ARG_NONE, 1'b0};
            47: return '{"TARE",       4'd4,  CMD_TARE,       ARG_NONE, 1'b0};
            48: return '{"PANELPINS",  4'd9,  CMD_PANELPINS,  ARG_NONE, 1'b0};
            49: return '{"PANEL",      4'd5,  CMD_PANELPINS,  ARG_NONE, 1'b0};
            50: return '{"HOME",       4'd4,  CMD_HOME,       ARG_NONE, 1'b0};
            51: return '{"G28",        4'd3,  CMD_HOME,       ARG_NONE, 1'b0};
            52: return '{"STOP",       4'd4,  CMD_STOP,       ARG_NONE, 1'b0};
            53: return '{"M112",       4'd4,  CMD_STOP,       ARG_NONE, 1'b0};
            54: return '{"BACKOFF",    4'd7,  CMD_BACKOFF,    ARG_NONE, 1'b0};
            55: return '{"HELP",       4'd4,  CMD_HELP,       ARG_NONE, 1'b0};
            default: return '{"?",     4'd1,  CMD_HELP,       ARG_NONE, 1'b0};
        endcase
    endfunction

    // boolean words, value carried in mm
    function automatic kw_t flag_entry(int i);
        case (i)
            0:  return '{"1",     4'd1, CMD_NONE, ARG_NONE, 1'b1};
            1:  return '{"ON",    4'd2, CMD_NONE, ARG_NONE, 1'b1};
            2:  return '{"TRUE",  4'd4, CMD_NONE, ARG_NONE, 1'b1};
            3:  return '{"0",     4'd1, CMD_NONE, ARG_NONE, 1'b0};
            4:  return '{"OFF",   4'd3, CMD_NONE, ARG_NONE, 1'b0};
            default: return '{"FALSE", 4'd5, CMD_NONE, ARG_NONE, 1'b0};
        endcase
    endfunction

    // character of a word at a position, zero past its end
    function automatic logic [7:0] kw_char(kw_t e, logic [LEN_W-1:0] pos);
        int sh_n;
        logic [KW_TEXT_W-1:0] w;
        sh_n = (int'(e.len) - 1 - int'(pos)) * 8;
        if (int'(pos) >= int'(e.len)) begin
            return 8'h00;
        end
        w = e.text >> sh_n;
        return w[7:0];
    endfunction

endpackage

// ===== rtl/tcd_token_mem.sv =====
module tcd_token_mem (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [tcd_pkg::ADDR_W-1:0] wr_addr,
    input  logic [7:0]                wr_data,
    input  logic                      rd_en,
    input  logic [tcd_pkg::ADDR_W-1:0] rd_addr,
    output logic [7:0]                rd_data
);

    logic [7:0] mem [tcd_pkg::STORE_DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/tcd_scan.sv =====
module tcd_scan (
    input  logic                       clk,
    input  logic                       rstn,
    input  logic                       wr,
    input  logic [7:0]                 wr_byte,
    input  logic                       clear,
    output logic                       mem_we,
    output logic [tcd_pkg::ADDR_W-1:0] mem_addr,
    output logic [7:0]                 mem_data,
    output tcd_pkg::scan_status_t      status
);

    localparam int LW = tcd_pkg::LEN_W;
    localparam int NW = tcd_pkg::NUM_W;
    localparam logic [tcd_pkg::SLOT_W-1:0] SLOT_FULL = tcd_pkg::SLOT_W'(tcd_pkg::SLOT_COUNT);

    logic [tcd_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [LW-1:0] len_reg  [tcd_pkg::SLOT_COUNT];
    logic [LW-1:0] len_next [tcd_pkg::SLOT_COUNT];
    logic [tcd_pkg::KW_COUNT-1:0]   kw_match_reg, kw_match_next;
    logic [tcd_pkg::FLAG_COUNT-1:0] fl_match_reg, fl_match_next;
    logic [7:0] c0_reg, c0_next, c1_reg, c1_next;
    logic [NW-1:0] acc0_reg, acc0_next, acc1_reg, acc1_next, acc2_reg, acc2_next;
    logic ok0_reg, ok0_next, ok1_reg, ok1_next, ok2_reg, ok2_next;

    logic [7:0]    ch;
    logic          is_ws, is_dig, active;
    logic [LW-1:0] cur_len, len_inc;
    logic [NW-1:0] dig;

    always_comb begin
        ch = wr_byte;
        if (wr_byte >= tcd_pkg::CH_LO_A && wr_byte <= tcd_pkg::CH_LO_Z) begin
            ch = wr_byte - tcd_pkg::CH_CASE;
        end
        is_ws = (wr_byte == tcd_pkg::CH_SPACE) || (wr_byte == tcd_pkg::CH_TAB) ||
                (wr_byte == tcd_pkg::CH_CR) || (wr_byte == tcd_pkg::CH_LF);
        is_dig  = (ch >= tcd_pkg::CH_ZERO) && (ch <= tcd_pkg::CH_NINE);
        dig     = NW'(ch - tcd_pkg::CH_ZERO);
        active  = wr && (slot_reg != SLOT_FULL);
        cur_len = (slot_reg == SLOT_FULL) ? '0 : len_reg[slot_reg];
        len_inc = cur_len + LW'(1);
    end

    assign mem_we   = active && !is_ws;
    assign mem_addr = tcd_pkg::ADDR_W'(slot_reg) * tcd_pkg::ADDR_W'(tcd_pkg::TOKEN_CAP)
                      + tcd_pkg::ADDR_W'(cur_len);
    assign mem_data = ch;

    always_comb begin
        slot_next     = slot_reg;
        len_next      = len_reg;
        kw_match_next = kw_match_reg;
        fl_match_next = fl_match_reg;
        c0_next       = c0_reg;
        c1_next       = c1_reg;
        acc0_next     = acc0_reg;
        acc1_next     = acc1_reg;
        acc2_next     = acc2_reg;
        ok0_next      = ok0_reg;
        ok1_next      = ok1_reg;
        ok2_next      = ok2_reg;
        if (clear) begin
            slot_next     = '0;
            for (int s = 0; s < tcd_pkg::SLOT_COUNT; s++) begin
                len_next[s] = '0;
            end
            kw_match_next = '1;
            fl_match_next = '1;
            acc0_next     = '0;
            acc1_next     = '0;
            acc2_next     = '0;
            ok0_next      = 1'b1;
            ok1_next      = 1'b1;
            ok2_next      = 1'b1;
        end else if (active) begin
            if (is_ws) begin
                if (cur_len != '0) begin
                    slot_next = slot_reg + tcd_pkg::SLOT_W'(1);
                end
            end else begin
                len_next[slot_reg] = len_inc;
                // a full token spills into the next slot
                if (len_inc >= LW'(tcd_pkg::TOKEN_CAP - 1)) begin
                    slot_next = slot_reg + tcd_pkg::SLOT_W'(1);
                end
                if (slot_reg == tcd_pkg::SLOT_W'(0)) begin
                    for (int i = 0; i < tcd_pkg::KW_COUNT; i++) begin
                        kw_match_next[i] = kw_match_reg[i] &&
                            (ch == tcd_pkg::kw_char(tcd_pkg::kw_entry(i), cur_len));
                    end
                end
                if (slot_reg == tcd_pkg::SLOT_W'(1)) begin
                    for (int i = 0; i < tcd_pkg::FLAG_COUNT; i++) begin
                        fl_match_next[i] = fl_match_reg[i] &&
                            (ch == tcd_pkg::kw_char(tcd_pkg::flag_entry(i), cur_len));
                    end
                    if (cur_len == LW'(0)) begin
                        c0_next = ch;
                    end
                    if (cur_len == LW'(1)) begin
                        c1_next = ch;
                    end
                    // digit runs starting at positions zero, one and two
                    ok0_next  = ok0_reg && is_dig;
                    acc0_next = (acc0_reg << 3) + (acc0_reg << 1) + dig;
                    if (cur_len >= LW'(1)) begin
                        ok1_next  = ok1_reg && is_dig;
                        acc1_next = (acc1_reg << 3) + (acc1_reg << 1) + dig;
                    end
                    if (cur_len >= LW'(2)) begin
                        ok2_next  = ok2_reg && is_dig;
                        acc2_next = (acc2_reg << 3) + (acc2_reg << 1) + dig;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            slot_reg     <= '0;
            for (int s = 0; s < tcd_pkg::SLOT_COUNT; s++) begin
                len_reg[s] <= '0;
            end
            kw_match_reg <= '1;
            fl_match_reg <= '1;
            acc0_reg     <= '0;
            acc1_reg     <= '0;
            acc2_reg     <= '0;
            ok0_reg      <= 1'b1;
            ok1_reg      <= 1'b1;
            ok2_reg      <= 1'b1;
        end else begin
            slot_reg     <= slot_next;
            len_reg      <= len_next;
            kw_match_reg <= kw_match_next;
            fl_match_reg <= fl_match_next;
            acc0_reg     <= acc0_next;
            acc1_reg     <= acc1_next;
            acc2_reg     <= acc2_next;
            ok0_reg      <= ok0_next;
            ok1_reg      <= ok1_next;
            ok2_reg      <= ok2_next;
        end
        c0_reg <= c0_next;
        c1_reg <= c1_next;
    end

    always_comb begin
        status          = '0;
        for (int s = 0; s < tcd_pkg::SLOT_COUNT; s++) begin
            status.len[s] = len_reg[s];
        end
        for (int i = 0; i < tcd_pkg::KW_COUNT; i++) begin
            if (kw_match_reg[i] && (len_reg[0] == LW'(tcd_pkg::kw_entry(i).len))) begin
                status.kw_found = 1'b1;
                status.kw_cmd   = status.kw_cmd | tcd_pkg::kw_entry(i).cmd;
                status.kw_arg   = status.kw_arg | tcd_pkg::kw_entry(i).arg;
                status.kw_mm    = status.kw_mm | tcd_pkg::kw_entry(i).mm;
            end
        end
        for (int i = 0; i < tcd_pkg::FLAG_COUNT; i++) begin
            if (fl_match_reg[i] && (len_reg[1] == LW'(tcd_pkg::flag_entry(i).len))) begin
                if (tcd_pkg::flag_entry(i).mm) begin
                    status.flag_on = 1'b1;
                end else begin
                    status.flag_off = 1'b1;
                end
            end
        end
        status.c0   = c0_reg;
        status.c1   = c1_reg;
        status.acc0 = acc0_reg;
        status.acc1 = acc1_reg;
        status.acc2 = acc2_reg;
        status.ok0  = ok0_reg;
        status.ok1  = ok1_reg;
        status.ok2  = ok2_reg;
    end

endmodule

// ===== rtl/tcd_seq.sv =====
module tcd_seq (
    input  logic                       clk,
    input  logic                       rstn,
    input  logic                       term,
    input  tcd_pkg::scan_status_t      status,
    input  logic [7:0]                 rd_data,
    input  logic                       out_ready,
    output logic                       in_ready,
    output logic                       clear,
    output logic                       rd_en,
    output logic [tcd_pkg::ADDR_W-1:0] rd_addr,
    output logic                       out_valid,
    output logic [1:0]                 out_kind,
    output logic [5:0]                 out_cmd,
    output logic                       out_hasn,
    output logic [tcd_pkg::NUM_W-1:0]  out_num,
    output logic                       out_mm,
    output logic [7:0]                 out_char,
    output logic                       out_last
);

    localparam int LW = tcd_pkg::LEN_W;
    localparam int NW = tcd_pkg::NUM_W;
    localparam int AW = tcd_pkg::ADDR_W;

    tcd_pkg::seq_state_t state_reg, state_next;
    logic [5:0]    cmd_reg, cmd_next;
    logic [LW-1:0] key_n_reg, key_n_next, text_n_reg, text_n_next, idx_reg, idx_next;
    logic          valid_reg, valid_next;
    logic [1:0]    kind_reg, kind_next;
    logic [5:0]    ocmd_reg, ocmd_next;
    logic          hasn_reg, hasn_next, mm_reg, mm_next, last_reg, last_next;
    logic [NW-1:0] num_reg, num_next;
    logic [7:0]    char_reg, char_next;

    logic          out_free, key_last, text_last;
    logic [5:0]    d_cmd;
    logic          d_hasn, d_mm, d_ok, s_ok, s_neg, a_ok, a_neg;
    logic [NW-1:0] d_num, s_mag, a_mag, d_mag;
    logic          d_neg;
    logic [LW-1:0] d_key_n, d_text_n, len1_cap, len2_cap;

    assign out_free  = !valid_reg || out_ready;
    assign key_last  = (idx_reg == key_n_reg - LW'(1));
    assign text_last = (idx_reg == text_n_reg - LW'(1));

    // argument decode from the scanner status
    always_comb begin
        len1_cap = (status.len[1] < LW'(tcd_pkg::KEY_LEN)) ? status.len[1]
                                                          : LW'(tcd_pkg::KEY_LEN);
        len2_cap = (status.len[2] < LW'(tcd_pkg::TEXT_LEN)) ? status.len[2]
                                                           : LW'(tcd_pkg::TEXT_LEN);
        if (status.len[1] >= LW'(1) &&
            (status.c0 == tcd_pkg::CH_MINUS || status.c0 == tcd_pkg::CH_PLUS)) begin
            s_ok  = (status.len[1] >= LW'(2)) && status.ok1;
            s_mag = status.acc1;
            s_neg = (status.c0 == tcd_pkg::CH_MINUS);
        end else begin
            s_ok  = (status.len[1] >= LW'(1)) && status.ok0;
            s_mag = status.acc0;
            s_neg = 1'b0;
        end
        // axis letter ahead of the value
        if (status.len[1] >= LW'(2) && status.c0 == tcd_pkg::CH_X) begin
            if (status.c1 == tcd_pkg::CH_MINUS || status.c1 == tcd_pkg::CH_PLUS) begin
                a_ok  = (status.len[1] >= LW'(3)) && status.ok2;
                a_mag = status.acc2;
                a_neg = (status.c1 == tcd_pkg::CH_MINUS);
            end else begin
                a_ok  = status.ok1;
                a_mag = status.acc1;
                a_neg = 1'b0;
            end
        end else begin
            a_ok  = s_ok;
            a_mag = s_mag;
            a_neg = s_neg;
        end

        d_cmd    = tcd_pkg::CMD_NONE;
        d_hasn   = 1'b0;
        d_mm     = 1'b0;
        d_ok     = 1'b1;
        d_mag    = '0;
        d_neg    = 1'b0;
        d_key_n  = '0;
        d_text_n = '0;
        if (status.len[0] != '0) begin
            d_cmd = tcd_pkg::CMD_UNKNOWN;
            if (status.kw_found) begin
                d_cmd = status.kw_cmd;
                d_mm  = status.kw_mm;
                case (tcd_pkg::arg_t'(status.kw_arg))
                    tcd_pkg::ARG_I32: begin
                        d_ok = s_ok; d_mag = s_mag; d_neg = s_neg; d_hasn = s_ok;
                    end
                    tcd_pkg::ARG_U32: begin
                        d_ok   = (status.len[1] >= LW'(1)) && status.ok0;
                        d_mag  = status.acc0;
                        d_hasn = d_ok;
                    end
                    tcd_pkg::ARG_BOOL: begin
                        d_ok   = status.flag_on || status.flag_off;
                        d_mag  = NW'(status.flag_on);
                        d_hasn = d_ok;
                    end
                    tcd_pkg::ARG_AXIS: begin
                        d_ok = a_ok; d_mag = a_mag; d_neg = a_neg; d_hasn = a_ok;
                    end
                    tcd_pkg::ARG_KEY: begin
                        d_key_n = len1_cap;
                    end
                    tcd_pkg::ARG_PAIR: begin
                        if (status.len[1] != '0 && status.len[2] != '0) begin
                            d_key_n  = len1_cap;
                            d_text_n = len2_cap;
                        end else begin
                            d_ok = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (!d_ok) begin
                d_cmd = tcd_pkg::CMD_UNKNOWN;
                d_mag = '0;
                d_mm  = 1'b0;
            end
        end
        d_num = d_neg ? (NW'(0) - d_mag) : d_mag;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tcd_pkg::ST_IDLE: begin
                if (term) begin
                    state_next = tcd_pkg::ST_DECODE;
                end
            end
            tcd_pkg::ST_DECODE: begin
                if (out_free) begin
                    if (d_key_n != '0) begin
                        state_next = tcd_pkg::ST_KEY_RD;
                    end else if (d_text_n != '0) begin
                        state_next = tcd_pkg::ST_TEXT_RD;
                    end else begin
                        state_next = tcd_pkg::ST_IDLE;
                    end
                end
            end
            tcd_pkg::ST_KEY_RD: begin
                state_next = tcd_pkg::ST_KEY_WR;
            end
            tcd_pkg::ST_KEY_WR: begin
                if (out_free) begin
                    if (!key_last) begin
                        state_next = tcd_pkg::ST_KEY_RD;
                    end else if (text_n_reg != '0) begin
                        state_next = tcd_pkg::ST_TEXT_RD;
                    end else begin
                        state_next = tcd_pkg::ST_IDLE;
                    end
                end
            end
            tcd_pkg::ST_TEXT_RD: begin
                state_next = tcd_pkg::ST_TEXT_WR;
            end
            tcd_pkg::ST_TEXT_WR: begin
                if (out_free) begin
                    if (!text_last) begin
                        state_next = tcd_pkg::ST_TEXT_RD;
                    end else begin
                        state_next = tcd_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = tcd_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        in_ready    = (state_reg == tcd_pkg::ST_IDLE);
        clear       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = AW'(tcd_pkg::TOKEN_CAP) + AW'(idx_reg);
        cmd_next    = cmd_reg;
        key_n_next  = key_n_reg;
        text_n_next = text_n_reg;
        idx_next    = idx_reg;
        valid_next  = valid_reg && !out_ready;
        kind_next   = kind_reg;
        ocmd_next   = ocmd_reg;
        hasn_next   = hasn_reg;
        num_next    = num_reg;
        mm_next     = mm_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        case (state_reg)
            tcd_pkg::ST_DECODE: begin
                if (out_free) begin
                    cmd_next    = d_cmd;
                    key_n_next  = d_key_n;
                    text_n_next = d_text_n;
                    idx_next    = '0;
                    valid_next  = 1'b1;
                    kind_next   = tcd_pkg::RK_SUMMARY;
                    ocmd_next   = d_cmd;
                    hasn_next   = d_hasn;
                    num_next    = d_num;
                    mm_next     = d_mm;
                    char_next   = '0;
                    last_next   = (d_key_n == '0) && (d_text_n == '0);
                    clear       = last_next;
                end
            end
            tcd_pkg::ST_KEY_RD: begin
                rd_en = 1'b1;
            end
            tcd_pkg::ST_TEXT_RD: begin
                rd_en   = 1'b1;
                rd_addr = AW'(2 * tcd_pkg::TOKEN_CAP) + AW'(idx_reg);
            end
            tcd_pkg::ST_KEY_WR, tcd_pkg::ST_TEXT_WR: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    ocmd_next  = cmd_reg;
                    hasn_next  = 1'b0;
                    num_next   = '0;
                    mm_next    = 1'b0;
                    char_next  = rd_data;
                    if (state_reg == tcd_pkg::ST_KEY_WR) begin
                        kind_next = tcd_pkg::RK_KEY;
                        last_next = key_last && (text_n_reg == '0);
                        idx_next  = key_last ? '0 : idx_reg + LW'(1);
                    end else begin
                        kind_next = tcd_pkg::RK_TEXT;
                        last_next = text_last;
                        idx_next  = idx_reg + LW'(1);
                    end
                    clear = last_next;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg <= tcd_pkg::ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
        cmd_reg    <= cmd_next;
        key_n_reg  <= key_n_next;
        text_n_reg <= text_n_next;
        idx_reg    <= idx_next;
        kind_reg   <= kind_next;
        ocmd_reg   <= ocmd_next;
        hasn_reg   <= hasn_next;
        num_reg    <= num_next;
        mm_reg     <= mm_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_cmd   = ocmd_reg;
    assign out_hasn  = hasn_reg;
    assign out_num   = num_reg;
    assign out_mm    = mm_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

// ===== rtl/text_command_line_decoder.sv =====
// channel | dir | tdata (low bit first)                              | tuser       | tlast
// s_      | in  | text byte [7:0]                                    | -           | -
// m_      | out | command kind, has number, number, unit mm, char    | result kind | final
//
// an ordinary byte other than white space is written into the token memory while a slot is free
// a zero byte starts a decode state that emits the summary, then a read and a write state for
// each key or value character, the read going through the registered token memory
// reset is synchronous on aresetn low and leaves an empty line
// a stalled result holds the sequencer; s_tready stays low until the line is done
module text_command_line_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // text_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // command_kind, has_number, number, unit_mm, char_out
    output logic [1:0]  m_tuser,   // result_kind
    output logic        m_tlast    // final_result
);

    logic                       in_acc, wr, term, clear, mem_we, rd_en;
    logic [tcd_pkg::ADDR_W-1:0] mem_addr, rd_addr;
    logic [7:0]                 mem_data, rd_data, out_char;
    tcd_pkg::scan_status_t      status;
    logic [5:0]                 out_cmd;
    logic                       out_hasn, out_mm;
    logic [tcd_pkg::NUM_W-1:0]  out_num;

    assign in_acc = s_tvalid && s_tready;
    assign wr     = in_acc && (s_tdata != 8'h00);
    assign term   = in_acc && (s_tdata == 8'h00);

    tcd_scan u_scan (
        .clk      (aclk),
        .rstn     (aresetn),
        .wr       (wr),
        .wr_byte  (s_tdata),
        .clear    (clear),
        .mem_we   (mem_we),
        .mem_addr (mem_addr),
        .mem_data (mem_data),
        .status   (status)
    );

    tcd_token_mem u_mem (
        .clk     (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_addr),
        .wr_data (mem_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tcd_seq u_seq (
        .clk       (aclk),
        .rstn      (aresetn),
        .term      (term),
        .status    (status),
        .rd_data   (rd_data),
        .out_ready (m_tready),
        .in_ready  (s_tready),
        .clear     (clear),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .out_valid (m_tvalid),
        .out_kind  (m_tuser),
        .out_cmd   (out_cmd),
        .out_hasn  (out_hasn),
        .out_num   (out_num),
        .out_mm    (out_mm),
        .out_char  (out_char),
        .out_last  (m_tlast)
    );

    assign m_tdata = {out_char, out_mm, out_num, out_hasn, out_cmd};

endmodule

// ===== tb/text_command_line_decoder_checker.sv =====
`timescale 1ns / 1ps

module text_command_line_decoder_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          lines_seen
);

    typedef struct packed {
        tcd_pkg::rkind_t kind;
        tcd_pkg::cmd_t   cmd;
        logic            has_num;
        logic [31:0]     num;
        logic            mm;
        logic [7:0]      ch;
        logic            fin;
    } line_result_t;

    typedef struct {
        string         word;
        tcd_pkg::cmd_t cmd;
        tcd_pkg::arg_t arg;
        logic          mm;
    } keyword_t;

    keyword_t     keywords[$];
    line_result_t expected_results[$];

    logic [7:0] tok_text [tcd_pkg::SLOT_COUNT][tcd_pkg::TOKEN_CAP];
    int         tok_len  [tcd_pkg::SLOT_COUNT];
    int         cur_slot;

    function automatic void add_kw(string w, tcd_pkg::cmd_t c, tcd_pkg::arg_t a, logic m);
        keyword_t k;
        k.word = w; k.cmd = c; k.arg = a; k.mm = m;
        keywords.push_back(k);
    endfunction

    initial begin
        add_kw("STATUS", tcd_pkg::CMD_STATUS, tcd_pkg::ARG_NONE, 0);
        add_kw("M114", tcd_pkg::CMD_STATUS, tcd_pkg::ARG_NONE, 0);
        add_kw("M119", tcd_pkg::CMD_STATUS, tcd_pkg::ARG_NONE, 0);
        add_kw("SAFETY", tcd_pkg::CMD_SAFETY, tcd_pkg::ARG_NONE, 0);
        add_kw("M122", tcd_pkg::CMD_SAFETY, tcd_pkg::ARG_NONE, 0);
        add_kw("CONFIG", tcd_pkg::CMD_CONFIG, tcd_pkg::ARG_KEY, 0);
        add_kw("CFG", tcd_pkg::CMD_CONFIG, tcd_pkg::ARG_KEY, 0);
        add_kw("SET", tcd_pkg::CMD_SET, tcd_pkg::ARG_PAIR, 0);
        add_kw("SAVE", tcd_pkg::CMD_SAVE, tcd_pkg::ARG_NONE, 0);
        add_kw("SAVECFG", tcd_pkg::CMD_SAVE, tcd_pkg::ARG_NONE, 0);
        add_kw("RESETCFG", tcd_pkg::CMD_RESETCFG, tcd_pkg::ARG_NONE, 0);
        add_kw("DEFAULTCFG", tcd_pkg::CMD_RESETCFG, tcd_pkg::ARG_NONE, 0);
        add_kw("REBOOT", tcd_pkg::CMD_REBOOT, tcd_pkg::ARG_NONE, 0);
        add_kw("RESET", tcd_pkg::CMD_REBOOT, tcd_pkg::ARG_NONE, 0);
        add_kw("BOOTLOADER", tcd_pkg::CMD_BOOTLOADER, tcd_pkg::ARG_NONE, 0);
        add_kw("RECOVERY", tcd_pkg::CMD_BOOTLOADER, tcd_pkg::ARG_NONE, 0);
        add_kw("BOOT", tcd_pkg::CMD_BOOT, tcd_pkg::ARG_NONE, 0);
        add_kw("START", tcd_pkg::CMD_BOOT, tcd_pkg::ARG_NONE, 0);
        add_kw("ENABLE", tcd_pkg::CMD_ENABLE, tcd_pkg::ARG_NONE, 0);
        add_kw("M17", tcd_pkg::CMD_ENABLE, tcd_pkg::ARG_NONE, 0);
        add_kw("DISABLE", tcd_pkg::CMD_DISABLE, tcd_pkg::ARG_NONE, 0);
        add_kw("M18", tcd_pkg::CMD_DISABLE, tcd_pkg::ARG_NONE, 0);
        add_kw("M84", tcd_pkg::CMD_DISABLE, tcd_pkg::ARG_NONE, 0);
        add_kw("HOLD", tcd_pkg::CMD_HOLD, tcd_pkg::ARG_BOOL, 0);
        add_kw("DRIVER", tcd_pkg::CMD_DRIVER, tcd_pkg::ARG_NONE, 0);
        add_kw(string'({8'h54, 8'h4d, 8'h43}), tcd_pkg::CMD_DRIVER, tcd_pkg::ARG_NONE, 0);
        add_kw("IRUN", tcd_pkg::CMD_IRUN, tcd_pkg::ARG_I32, 0);
        add_kw("IHOLD", tcd_pkg::CMD_IHOLD, tcd_pkg::ARG_I32, 0);
        add_kw("IHOLDDELAY", tcd_pkg::CMD_IHOLDDELAY, tcd_pkg::ARG_I32, 0);
        add_kw("IHOLDD", tcd_pkg::CMD_IHOLDDELAY, tcd_pkg::ARG_I32, 0);
        add_kw("SGTHRS", tcd_pkg::CMD_SGTHRS, tcd_pkg::ARG_I32, 0);
        add_kw("MOVEABS", tcd_pkg::CMD_MOVEABS, tcd_pkg::ARG_AXIS, 0);
        add_kw("G0", tcd_pkg::CMD_MOVEABS, tcd_pkg::ARG_AXIS, 1);
        add_kw("G1", tcd_pkg::CMD_MOVEABS, tcd_pkg::ARG_AXIS, 1);
        add_kw("MOVEREL", tcd_pkg::CMD_MOVEREL, tcd_pkg::ARG_I32, 0);
        add_kw("JOG", tcd_pkg::CMD_MOVEREL, tcd_pkg::ARG_I32, 0);
        add_kw("SETPOS", tcd_pkg::CMD_SETPOS, tcd_pkg::ARG_I32, 0);
        add_kw("CYCLE", tcd_pkg::CMD_CYCLE, tcd_pkg::ARG_I32, 0);
        add_kw("PRESSPOS", tcd_pkg::CMD_PRESSPOS, tcd_pkg::ARG_I32, 0);
        add_kw("SIMLOAD", tcd_pkg::CMD_SIMLOAD, tcd_pkg::ARG_U32, 0);
        add_kw("SIMRAW", tcd_pkg::CMD_SIMLOAD, tcd_pkg::ARG_U32, 0);
        add_kw("SIMTHRESH", tcd_pkg::CMD_SIMTHRESH, tcd_pkg::ARG_U32, 0);
        add_kw("LOADTHRESH", tcd_pkg::CMD_SIMTHRESH, tcd_pkg::ARG_U32, 0);
        add_kw("SIMMECH", tcd_pkg::CMD_SIMMECH, tcd_pkg::ARG_BOOL, 0);
        add_kw("SIMSTALL", tcd_pkg::CMD_SIMSTALL, tcd_pkg::ARG_BOOL, 0);
        add_kw("SIMCLEAR", tcd_pkg::CMD_SIMCLEAR, tcd_pkg::ARG_NONE, 0);
        add_kw("ZERO", tcd_pkg::CMD_TARE, tcd_pkg::ARG_NONE, 0);
        add_kw("TARE", tcd_pkg::CMD_TARE, tcd_pkg::ARG_NONE, 0);
        add_kw("PANELPINS", tcd_pkg::CMD_PANELPINS, tcd_pkg::ARG_NONE, 0);
        add_kw("PANEL", tcd_pkg::CMD_PANELPINS, tcd_pkg::ARG_NONE, 0);
        add_kw("HOME", tcd_pkg::CMD_HOME, tcd_pkg::ARG_NONE, 0);
        add_kw("G28", tcd_pkg::CMD_HOME, tcd_pkg::ARG_NONE, 0);
        add_kw("STOP", tcd_pkg::CMD_STOP, tcd_pkg::ARG_NONE, 0);
        add_kw("M112", tcd_pkg::CMD_STOP, tcd_pkg::ARG_NONE, 0);
        add_kw("BACKOFF", tcd_pkg::CMD_BACKOFF, tcd_pkg::ARG_NONE, 0);
        add_kw("HELP", tcd_pkg::CMD_HELP, tcd_pkg::ARG_NONE, 0);
        add_kw("?", tcd_pkg::CMD_HELP, tcd_pkg::ARG_NONE, 0);
    end

    function automatic bit token_is(int slot, string w);
        if (w.len() != tok_len[slot]) return 0;
        for (int i = 0; i < w.len(); i++)
            if (tok_text[slot][i] != w[i]) return 0;
        return 1;
    endfunction

    function automatic bit digits_from(int slot, int pos, output logic [31:0] val);
        logic [31:0] acc;
        acc = 0;
        val = 0;
        if (pos >= tok_len[slot]) return 0;
        for (int i = pos; i < tok_len[slot]; i++) begin
            if (tok_text[slot][i] < tcd_pkg::CH_ZERO || tok_text[slot][i] > tcd_pkg::CH_NINE)
                return 0;
            acc = acc * 32'd10 + 32'(tok_text[slot][i] - tcd_pkg::CH_ZERO);
        end
        val = acc;
        return 1;
    endfunction

    function automatic bit signed_from(int slot, int pos, output logic [31:0] val);
        bit neg;
        logic [31:0] mag;
        neg = 0;
        val = 0;
        if (pos < tok_len[slot]) begin
            if (tok_text[slot][pos] == tcd_pkg::CH_MINUS) begin
                neg = 1; pos++;
            end else if (tok_text[slot][pos] == tcd_pkg::CH_PLUS) begin
                pos++;
            end
        end
        if (!digits_from(slot, pos, mag)) return 0;
        val = neg ? -mag : mag;
        return 1;
    endfunction

    function automatic void push_result(tcd_pkg::rkind_t k, tcd_pkg::cmd_t c, logic h,
                                        logic [31:0] n, logic m, logic [7:0] ch);
        line_result_t r;
        r = '{k, c, h, n, m, ch, 1'b0};
        expected_results.push_back(r);
    endfunction

    // the terminator: decode the line and queue its results
    function automatic void decode_line();
        tcd_pkg::cmd_t cmd;
        tcd_pkg::arg_t arg;
        logic          mm, hasn, ok;
        logic [31:0]   num;
        int            key_n, text_n;
        cmd = tcd_pkg::CMD_NONE; arg = tcd_pkg::ARG_NONE; mm = 0; hasn = 0; ok = 1; num = 0;
        key_n = 0; text_n = 0;
        if (tok_len[0] != 0) begin
            cmd = tcd_pkg::CMD_UNKNOWN;
            foreach (keywords[i]) begin
                if (token_is(0, keywords[i].word)) begin
                    cmd = keywords[i].cmd; arg = keywords[i].arg; mm = keywords[i].mm;
                    break;
                end
            end
            case (arg)
                tcd_pkg::ARG_I32: ok = signed_from(1, 0, num);
                tcd_pkg::ARG_U32: ok = digits_from(1, 0, num);
                tcd_pkg::ARG_BOOL: begin
                    if (token_is(1, "1") || token_is(1, "ON") || token_is(1, "TRUE"))
                        num = 1;
                    else if (!(token_is(1, "0") || token_is(1, "OFF") || token_is(1, "FALSE")))
                        ok = 0;
                end
                tcd_pkg::ARG_AXIS: begin
                    if (tok_len[1] >= 2 && tok_text[1][0] == tcd_pkg::CH_X)
                        ok = signed_from(1, 1, num);
                    else
                        ok = signed_from(1, 0, num);
                end
                tcd_pkg::ARG_KEY: begin
                    key_n = tok_len[1] < tcd_pkg::KEY_LEN ? tok_len[1] : tcd_pkg::KEY_LEN;
                end
                tcd_pkg::ARG_PAIR: begin
                    if (tok_len[1] != 0 && tok_len[2] != 0) begin
                        key_n  = tok_len[1] < tcd_pkg::KEY_LEN ? tok_len[1] : tcd_pkg::KEY_LEN;
                        text_n = tok_len[2] < tcd_pkg::TEXT_LEN ? tok_len[2]
                                                                 : tcd_pkg::TEXT_LEN;
                    end else begin
                        ok = 0;
                    end
                end
                default: ;
            endcase
            if (arg inside {tcd_pkg::ARG_I32, tcd_pkg::ARG_U32, tcd_pkg::ARG_BOOL,
                            tcd_pkg::ARG_AXIS}) hasn = ok;
            if (!ok) begin
                cmd = tcd_pkg::CMD_UNKNOWN; num = 0; mm = 0;
            end
        end
        push_result(tcd_pkg::RK_SUMMARY, cmd, hasn, num, mm, 8'h00);
        for (int i = 0; i < key_n; i++)
            push_result(tcd_pkg::RK_KEY, cmd, 0, 0, 0, tok_text[1][i]);
        for (int i = 0; i < text_n; i++)
            push_result(tcd_pkg::RK_TEXT, cmd, 0, 0, 0, tok_text[2][i]);
        expected_results[$].fin = 1'b1;
        foreach (tok_len[i]) tok_len[i] = 0;
        cur_slot = 0;
    endfunction

    function automatic void take_byte(logic [7:0] c);
        if (c == 8'h00) begin
            decode_line();
            lines_seen++;
            return;
        end
        if (cur_slot >= tcd_pkg::SLOT_COUNT) return;
        if (c == tcd_pkg::CH_SPACE || c == tcd_pkg::CH_TAB || c == tcd_pkg::CH_CR ||
            c == tcd_pkg::CH_LF) begin
            if (tok_len[cur_slot] > 0) cur_slot++;
            return;
        end
        if (c >= tcd_pkg::CH_LO_A && c <= tcd_pkg::CH_LO_Z) c = c - tcd_pkg::CH_CASE;
        tok_text[cur_slot][tok_len[cur_slot]] = c;
        tok_len[cur_slot]++;
        if (tok_len[cur_slot] >= tcd_pkg::TOKEN_CAP - 1) cur_slot++;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result();
        line_result_t want;
        if (expected_results.size() == 0) begin
            $error("result with nothing expected: tdata 0x%0h", m_tdata);
            fail_count++;
            return;
        end
        want = expected_results.pop_front();
        check_field("result_kind", want.kind, m_tuser);
        check_field("command_kind", want.cmd, m_tdata[5:0]);
        check_field("has_number", want.has_num, m_tdata[6]);
        check_field("number", want.num, m_tdata[38:7]);
        check_field("unit_mm", want.mm, m_tdata[39]);
        check_field("char_out", want.ch, m_tdata[47:40]);
        check_field("final_result", want.fin, m_tlast);
    endtask

    initial begin
        fail_count = 0;
        results_seen = 0;
        lines_seen = 0;
        pending = 0;
        cur_slot = 0;
        foreach (tok_len[i]) tok_len[i] = 0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                check_result();
                results_seen++;
            end
            if (s_tvalid && s_tready) take_byte(s_tdata);
        end
        pending = expected_results.size();
    end

endmodule

// ===== tb/text_command_line_decoder_tb.sv =====
`timescale 1ns / 1ps

module text_command_line_decoder_tb;

    localparam int CYCLE_LIMIT = 1000000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    int          fail_count, pending, results_seen, lines_seen;
    int          bytes_sent;
    int          cycle_count;
    bit          sending_done;

    text_command_line_decoder DUT (.*);

    text_command_line_decoder_checker checker_i (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
        .m_tdata, .m_tuser, .m_tlast, .fail_count, .pending, .results_seen, .lines_seen
    );

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("status: fail");
                $finish;
            end
        end
    end

    // receiver: a fresh stall length after every result
    initial begin
        int gap;
        m_tready = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                m_tready <= 0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= b;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        @(negedge aclk);
        bytes_sent++;
    endtask

    task automatic send_text(string t);
        for (int i = 0; i < t.len(); i++) send_byte(t[i]);
    endtask

    task automatic send_line(string t);
        send_text(t);
        send_byte(8'h00);
    endtask

    function automatic string rand_number();
        string s;
        int n;
        s = "";
        case ($urandom_range(0, 2))
            0: s = "-";
            1: s = "+";
            default: ;
        endcase
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 5);
        for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(48, 57)))};
        return s;
    endfunction

    function automatic string rand_word(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: s = {s, string'(8'($urandom_range(97, 122)))};
                1: s = {s, string'(8'($urandom_range(65, 90)))};
                2: s = {s, string'(8'($urandom_range(48, 57)))};
                default: s = {s, string'(8'($urandom_range(33, 126)))};
            endcase
        end
        return s;
    endfunction

    function automatic string rand_sep();
        case ($urandom_range(0, 5))
            0: return "\t";
            1: return "  ";
            2: return "\r\n";
            default: return " ";
        endcase
    endfunction

    string cmd_words[] = '{"status", "M114", "m119", "SAFETY", "m122", "config", "cfg",
        "set", "save", "savecfg", "resetcfg", "defaultcfg", "reboot", "reset",
        "bootloader", "recovery", "boot", "start", "enable", "m17", "disable", "m18",
        "m84", "hold", "driver", "irun", "ihold", "iholddelay", "iholdd", "sgthrs",
        "moveabs", "g0", "G1", "moverel", "jog", "setpos", "cycle", "presspos",
        "simload", "simraw", "simthresh", "loadthresh", "simmech", "simstall",
        "simclear", "zero", "tare", "panelpins", "panel", "home", "g28", "stop",
        "m112", "backoff", "help", "?", "bogus", "statusx"};
    string flag_words[] = '{"1", "on", "TRUE", "0", "off", "false", "maybe", "2"};

    task automatic random_line();
        string w, line;
        int    k;
        k = $urandom_range(0, 9);
        if (k == 0) begin
            // noise: any bytes but zero, occasional high bit
            for (int i = $urandom_range(0, 40); i > 0; i--)
                send_byte(8'($urandom_range(1, 255)));
            send_byte(8'h00);
            return;
        end
        w = cmd_words[$urandom_range(0, cmd_words.size() - 1)];
        line = w;
        if ($urandom_range(0, 3) == 0) line = {" ", line};
        case ($urandom_range(0, 5))
            0: line = {line, rand_sep(), flag_words[$urandom_range(0, 7)]};
            1: line = {line, rand_sep(), "x", rand_number()};
            2: line = {line, rand_sep(), rand_word($urandom_range(1, 20)), rand_sep(),
                       rand_word($urandom_range(1, 20))};
            3: line = {line, rand_sep(), rand_word($urandom_range(1, 6))};
            4: line = {line};
            default: line = {line, rand_sep(), rand_number()};
        endcase
        if ($urandom_range(0, 7) == 0) line = {line, rand_sep(), rand_word(5), " tail junk"};
        if ($urandom_range(0, 3) == 0) line = {line, rand_sep()};
        send_line(line);
    endtask

    initial begin
        string long31;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = 0;
        bytes_sent = 0;
        sending_done = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed: empty, keyword kinds, argument corner cases
        send_line("");
        send_line("set key 4294967295");
        send_line("G1 X-2147483648");
        send_line("irun 99999999999");
        send_line("hold on");
        send_line("cfg");
        send_line("set onlykey");
        send_line("simload -5");
        send_line("moveabs X");
        long31 = "abcdefghijklmnopqrstuvwxyz01234";
        send_line({"set ", long31, "z ", long31});
        send_line({string'({8'hff, 8'h80, 8'h7f, 8'h01}), " a b c d"});

        // random lines until about 360 bytes went in
        while (bytes_sent < 360) random_line();
        sending_done = 1;
        s_tvalid <= 0;
    end

    initial begin
        wait (sending_done);
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("%0d bytes in %0d lines sent, %0d results checked", bytes_sent, lines_seen,
                 results_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
